>>> rtl/rotation_matrix_to_quaternion_top_defines.svh
// ----------------------------------------------------------------------------
// rotation matrix to quaternion - assertion macros
// shared property forms used by the rtl checks
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RMQ_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("rmq check failed");

// next-cycle implication, disabled in reset
`define RMQ_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("rmq check failed");

`endif

>>> rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// widths and pipeline payload types of the matrix to quaternion block
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int RadW      = 52;  // radicand, two bits per root step
  localparam int RootW     = 26;
  localparam int RootSteps = 26;
  localparam int RemW      = 28;
  localparam int MagW      = 40;  // numerator magnitude
  localparam int DivW      = 42;
  localparam int QuoW      = 16;
  localparam int IrootW    = 18;
  localparam int FrontStages = 3;
  localparam int Latency   = FrontStages + RootSteps + 1 + QuoW + 1;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef struct packed {
    logic            sgn;
    logic [MagW-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic        degen;
    logic [3:0]  root_lane;
    lane_t [3:0] lane;
  } item_t;

  typedef struct packed {
    logic            sgn;
    logic            ovf;
    logic [DivW-1:0] rem;
    logic [QuoW-1:0] quo;
  } dlane_t;

  typedef struct packed {
    logic              degen;
    logic [3:0]        root_lane;
    logic [RootW-1:0]  dvs;
    logic [IrootW-1:0] iroot;
    dlane_t [3:0]      lane;
  } dword_t;

endpackage

>>> rtl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// 3x3 rotation matrix in q2.14 to unit quaternion in q2.14, shepperd method
// ----------------------------------------------------------------------------
//  channel   direction  ports                         handshake
//  command   in         start_i, r00_i .. r22_i        start_i & !busy_o
//  result    out        valid_o, qx_o .. qw_o,         one-cycle strobe
//                       degenerate_o
//
// - one transaction accepted per clock; busy_o stays low, the pipe never stalls
// - pipeline: 3 front stages, 26 square-root digit stages
//   (one per two radicand bits), 1 numerator setup stage, 16 quotient-bit
//   divider stages and the output register
// - rst_ni clears only the valid bits; payload registers carry no reset
// - the receiver cannot stall, so each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] r00_i,
  input  logic signed [15:0] r01_i,
  input  logic signed [15:0] r02_i,
  input  logic signed [15:0] r10_i,
  input  logic signed [15:0] r11_i,
  input  logic signed [15:0] r12_i,
  input  logic signed [15:0] r20_i,
  input  logic signed [15:0] r21_i,
  input  logic signed [15:0] r22_i,
  output logic               valid_o,
  output logic signed [15:0] qx_o,
  output logic signed [15:0] qy_o,
  output logic signed [15:0] qz_o,
  output logic signed [15:0] qw_o,
  output logic               degenerate_o
);

  // fully pipelined, nothing ever holds the input off
  assign busy_o = 1'b0;

  // square root chain
  logic             sv   [RootSteps+1];
  item_t            sitm [RootSteps+1];
  logic [RadW-1:0]  srad [RootSteps+1];
  logic [RemW-1:0]  srem [RootSteps+1];
  logic [RootW-1:0] sroot[RootSteps+1];

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .r00_i   (r00_i),
    .r01_i   (r01_i),
    .r02_i   (r02_i),
    .r10_i   (r10_i),
    .r11_i   (r11_i),
    .r12_i   (r12_i),
    .r20_i   (r20_i),
    .r21_i   (r21_i),
    .r22_i   (r22_i),
    .valid_o (sv[0]),
    .item_o  (sitm[0]),
    .rad_o   (srad[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar g = 0; g < RootSteps; g++) begin : g_sqrt
    rmq_sqrt_stage #(.Step(RootSteps-1-g)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[g]),
      .item_i  (sitm[g]),
      .rad_i   (srad[g]),
      .rem_i   (srem[g]),
      .root_i  (sroot[g]),
      .valid_o (sv[g+1]),
      .item_o  (sitm[g+1]),
      .rad_o   (srad[g+1]),
      .rem_o   (srem[g+1]),
      .root_o  (sroot[g+1])
    );
  end

  // numerator setup: add half the divisor for rounding, flag quotients
  // that would need more than the divider's 16 bits
  item_t            pitm;
  logic [RootW-1:0] proot;
  logic [DivW-1:0]  dtop;
  logic [DivW-1:0]  nump [4];
  dword_t           word_d;
  logic             dv   [QuoW+1];
  dword_t           dwd  [QuoW+1];
  logic             pv_q;
  dword_t           pw_q;

  assign pitm  = sitm[RootSteps];
  assign proot = sroot[RootSteps];

  always_comb begin
    dtop = {proot, {(DivW-RootW){1'b0}}};
    word_d.degen     = pitm.degen;
    word_d.root_lane = pitm.root_lane;
    word_d.dvs       = proot;
    word_d.iroot     = IrootW'(({1'b0, proot} + 27'd256) >> 9);
    for (int a = 0; a < 4; a++) begin
      nump[a] = {{(DivW-MagW){1'b0}}, pitm.lane[a].mag}
              + {{(DivW-RootW+1){1'b0}}, proot[RootW-1:1]};
      word_d.lane[a].sgn = pitm.lane[a].sgn;
      word_d.lane[a].ovf = (nump[a] >= dtop);
      word_d.lane[a].rem = nump[a];
      word_d.lane[a].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= sv[RootSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q <= word_d;
  end

  assign dv[0]  = pv_q;
  assign dwd[0] = pw_q;

  for (genvar g = 0; g < QuoW; g++) begin : g_div
    rmq_div_stage #(.Bit(QuoW-1-g)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[g]),
      .word_i  (dwd[g]),
      .valid_o (dv[g+1]),
      .word_o  (dwd[g+1])
    );
  end

  // sign, saturation and degenerate masking
  dword_t             fw;
  logic signed [15:0] qv [4];
  logic               valid_q, degen_q;
  logic signed [15:0] q_q [4];

  assign fw = dwd[QuoW];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      if (fw.root_lane[a]) begin
        qv[a] = (fw.iroot > IrootW'(32767)) ? 16'sh7fff : 16'(fw.iroot);
      end else if (!fw.lane[a].sgn) begin
        qv[a] = (fw.lane[a].ovf || fw.lane[a].quo > 16'd32767)
              ? 16'sh7fff : 16'(fw.lane[a].quo);
      end else begin
        qv[a] = (fw.lane[a].ovf || fw.lane[a].quo > 16'd32768)
              ? 16'sh8000 : 16'(-fw.lane[a].quo);
      end
      if (fw.degen) qv[a] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q     <= qv;
    degen_q <= fw.degen;
  end

  assign valid_o      = valid_q;
  assign qx_o         = q_q[0];
  assign qy_o         = q_q[1];
  assign qz_o         = q_q[2];
  assign qw_o         = q_q[3];
  assign degenerate_o = degen_q;

  // a result only appears a fixed latency after an accepted transaction
  `RMQ_ASSERT_IMP(a_lat, valid_o, $past(start_i && !busy_o, Latency))
  // degenerate results carry an all-zero quaternion
  `RMQ_ASSERT_IMP(a_degen_zero, valid_o && degenerate_o,
                  qx_o == '0 && qy_o == '0 && qz_o == '0 && qw_o == '0)
  // a root-derived qx component is never negative
  `RMQ_ASSERT_NEXT(a_root_pos, dv[QuoW] && !fw.degen && fw.root_lane[0], !qx_o[15])

endmodule

>>> rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// trace, branch pick, squares and radicand over three register stages
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] r00_i,
  input  logic signed [15:0] r01_i,
  input  logic signed [15:0] r02_i,
  input  logic signed [15:0] r10_i,
  input  logic signed [15:0] r11_i,
  input  logic signed [15:0] r12_i,
  input  logic signed [15:0] r20_i,
  input  logic signed [15:0] r21_i,
  input  logic signed [15:0] r22_i,
  output logic               valid_o,
  output item_t              item_o,
  output logic [RadW-1:0]    rad_o
);

  localparam logic signed [17:0] One = 18'sd16384;

  // stage 1
  logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [17:0] trace;
  logic signed [17:0] c_d [4];
  logic signed [17:0] v_d, dw_d, dj_d, dk_d;
  axis_e              ax_d;
  logic signed [17:0] c_q [4];
  logic signed [17:0] v1_q, dw_q, dj_q, dk_q;
  axis_e              ax_q;
  logic               tr1_q, valid1_q;

  assign e00 = {{2{r00_i[15]}}, r00_i};
  assign e01 = {{2{r01_i[15]}}, r01_i};
  assign e02 = {{2{r02_i[15]}}, r02_i};
  assign e10 = {{2{r10_i[15]}}, r10_i};
  assign e11 = {{2{r11_i[15]}}, r11_i};
  assign e12 = {{2{r12_i[15]}}, r12_i};
  assign e20 = {{2{r20_i[15]}}, r20_i};
  assign e21 = {{2{r21_i[15]}}, r21_i};
  assign e22 = {{2{r22_i[15]}}, r22_i};

  always_comb begin
    trace  = e00 + e11 + e22;
    c_d[0] = e21 - e12;
    c_d[1] = e02 - e20;
    c_d[2] = e10 - e01;
    c_d[3] = trace + One;
    // largest diagonal, lower index wins ties
    ax_d = (e11 > e00) ? AxisY : AxisX;
    if (ax_d == AxisY) begin
      if (e22 > e11) ax_d = AxisZ;
    end else begin
      if (e22 > e00) ax_d = AxisZ;
    end
    unique case (ax_d)
      AxisY: begin
        v_d  = e11 - e22 - e00 + One;
        dw_d = e02 - e20;
        dj_d = e21 + e12;
        dk_d = e01 + e10;
      end
      AxisZ: begin
        v_d  = e22 - e00 - e11 + One;
        dw_d = e10 - e01;
        dj_d = e02 + e20;
        dk_d = e12 + e21;
      end
      default: begin
        v_d  = e00 - e11 - e22 + One;
        dw_d = e21 - e12;
        dj_d = e10 + e01;
        dk_d = e20 + e02;
      end
    endcase
  end

  // stage 2
  logic signed [35:0] prod [4];
  logic signed [17:0] lval [4];
  logic [17:0]        labs [4];
  logic [3:0]         rl_d;
  lane_t [3:0]        lane_d;
  logic [34:0]        sq_q [4];
  lane_t [3:0]        lane_q;
  logic [3:0]         rl_q;
  logic signed [17:0] v2_q;
  logic               tr2_q, vpos_q, valid2_q;

  always_comb begin
    lval = c_q;
    rl_d = 4'b0000;
    if (!tr1_q) begin
      lval[3] = dw_q;
      unique case (ax_q)
        AxisY: begin
          lval[0] = dk_q; lval[1] = '0; lval[2] = dj_q; rl_d = 4'b0010;
        end
        AxisZ: begin
          lval[0] = dj_q; lval[1] = dk_q; lval[2] = '0; rl_d = 4'b0100;
        end
        default: begin
          lval[0] = '0; lval[1] = dj_q; lval[2] = dk_q; rl_d = 4'b0001;
        end
      endcase
    end
    for (int a = 0; a < 4; a++) begin
      prod[a] = c_q[a] * c_q[a];
      labs[a] = lval[a][17] ? 18'(-lval[a]) : 18'(lval[a]);
      lane_d[a].sgn = lval[a][17];
      lane_d[a].mag = tr1_q ? {labs[a], 22'b0} : {1'b0, labs[a], 21'b0};
    end
  end

  // stage 3
  logic [36:0] len;
  logic        degen;
  item_t       item_q;
  logic [RadW-1:0] rad_q;
  logic        valid3_q;

  always_comb begin
    len   = {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]} + {2'b0, sq_q[3]};
    degen = tr2_q ? (len == '0) : !vpos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    v1_q   <= v_d;
    dw_q   <= dw_d;
    dj_q   <= dj_d;
    dk_q   <= dk_d;
    ax_q   <= ax_d;
    tr1_q  <= !trace[17];
    for (int a = 0; a < 4; a++) sq_q[a] <= prod[a][34:0];
    lane_q <= lane_d;
    rl_q   <= rl_d;
    v2_q   <= v1_q;
    tr2_q  <= tr1_q;
    vpos_q <= !v1_q[17] && (v1_q != '0);
    item_q.degen     <= degen;
    item_q.root_lane <= rl_q;
    item_q.lane      <= lane_q;
    if (degen) begin
      rad_q <= '0;
    end else if (tr2_q) begin
      rad_q <= {1'b0, len[34:0], 16'b0};
    end else begin
      rad_q <= {5'b0, v2_q[16:0], 30'b0};
    end
  end

  assign valid_o = valid3_q;
  assign item_o  = item_q;
  assign rad_o   = rad_q;

endmodule

>>> rtl/rmq_sqrt_stage.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_stage
// one digit of the integer square root, two radicand bits per stage
// ----------------------------------------------------------------------------
module rmq_sqrt_stage import rmq_pkg::*; #(
  parameter int Step = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  output item_t            item_o,
  output logic [RadW-1:0]  rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [RootW-1:0] root_o
);

  logic [RemW+1:0] shifted, trial;
  logic [RemW-1:0] rem_d;
  logic [RootW-1:0] root_d;
  logic            valid_q;
  item_t           item_q;
  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q;
  logic [RootW-1:0] root_q;

  always_comb begin
    shifted = {rem_i, rad_i[2*Step+1 -: 2]};
    trial   = {2'b0, root_i, 2'b01};
    if (shifted >= trial) begin
      rem_d  = RemW'(shifted - trial);
      root_d = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_d  = shifted[RemW-1:0];
      root_d = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    rad_q  <= rad_i;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

>>> rtl/rmq_div_stage.sv
// ----------------------------------------------------------------------------
// rmq_div_stage
// one quotient bit of restoring division on all four lanes
// ----------------------------------------------------------------------------
module rmq_div_stage import rmq_pkg::*; #(
  parameter int Bit = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  dword_t word_i,
  output logic   valid_o,
  output dword_t word_o
);

  logic [DivW-1:0] dshift;
  dword_t          word_d, word_q;
  logic            valid_q;

  always_comb begin
    dshift = {{(DivW-RootW){1'b0}}, word_i.dvs} << Bit;
    word_d = word_i;
    for (int a = 0; a < 4; a++) begin
      if (word_i.lane[a].rem >= dshift) begin
        word_d.lane[a].rem      = word_i.lane[a].rem - dshift;
        word_d.lane[a].quo[Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> tb/sv/rotation_matrix_to_quaternion_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_checker
// watches the command and result channels, predicts each quaternion and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic signed [15:0] r00_i,
  input  logic signed [15:0] r01_i,
  input  logic signed [15:0] r02_i,
  input  logic signed [15:0] r10_i,
  input  logic signed [15:0] r11_i,
  input  logic signed [15:0] r12_i,
  input  logic signed [15:0] r20_i,
  input  logic signed [15:0] r21_i,
  input  logic signed [15:0] r22_i,
  input  logic               valid_o,
  input  logic signed [15:0] qx_o,
  input  logic signed [15:0] qy_o,
  input  logic signed [15:0] qz_o,
  input  logic signed [15:0] qw_o,
  input  logic               degenerate_o,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [15:0] q [4];
    logic               degen;
  } quat_t;

  quat_t quat_q [$];
  int    err_cnt = 0;

  assign pending_o = quat_q.size();
  assign errors_o  = err_cnt;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // divide to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic quat_t shepperd(longint m [3][3]);
    quat_t  res;
    longint c [4];
    longint tr, len, v, root;
    int     i, j, k;
    for (int a = 0; a < 4; a++) c[a] = 0;
    res.degen = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr >= 0) begin
      c[0] = m[2][1] - m[1][2];
      c[1] = m[0][2] - m[2][0];
      c[2] = m[1][0] - m[0][1];
      c[3] = tr + 16384;
      len = 0;
      for (int a = 0; a < 4; a++) len += c[a] * c[a];
      if (len == 0) begin
        res.degen = 1'b1;
        for (int a = 0; a < 4; a++) c[a] = 0;
      end else begin
        root = int_sqrt(len << 16);
        for (int a = 0; a < 4; a++) c[a] = round_div(c[a] * 4194304, root);
      end
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      v = m[i][i] - m[j][j] - m[k][k] + 16384;
      if (v <= 0) begin
        res.degen = 1'b1;
      end else begin
        root = int_sqrt(v << 30);
        c[i] = round_div(root, 512);
        c[3] = round_div((m[k][j] - m[j][k]) * 2097152, root);
        c[j] = round_div((m[j][i] + m[i][j]) * 2097152, root);
        c[k] = round_div((m[k][i] + m[i][k]) * 2097152, root);
      end
    end
    for (int a = 0; a < 4; a++) res.q[a] = clamp16(c[a]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    longint m [3][3];
    quat_t  want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        m[0][0] = r00_i; m[0][1] = r01_i; m[0][2] = r02_i;
        m[1][0] = r10_i; m[1][1] = r11_i; m[1][2] = r12_i;
        m[2][0] = r20_i; m[2][1] = r21_i; m[2][2] = r22_i;
        quat_q.push_back(shepperd(m));
      end
      if (valid_o) begin
        if (quat_q.size() == 0) begin
          report_mismatch("unexpected result, queue depth", 1, 0);
        end else begin
          want = quat_q.pop_front();
          if (qx_o !== want.q[0]) report_mismatch("qx", qx_o, want.q[0]);
          if (qy_o !== want.q[1]) report_mismatch("qy", qy_o, want.q[1]);
          if (qz_o !== want.q[2]) report_mismatch("qz", qz_o, want.q[2]);
          if (qw_o !== want.q[3]) report_mismatch("qw", qw_o, want.q[3]);
          if (degenerate_o !== want.degen)
            report_mismatch("degenerate", degenerate_o, want.degen);
        end
      end
    end
  end

endmodule

>>> tb/sv/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top_tb
// directed and random matrices into the quaternion block; a side checker
// predicts every result and this top gives the verdict
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_tb;
  import rmq_pkg::*;

  localparam int NumRandom = 1200;
  localparam int IdleLimit = 4 * Latency + 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] r_i [9] = '{default: '0};
  logic               valid_o;
  logic signed [15:0] qx_o, qy_o, qz_o, qw_o;
  logic               degenerate_o;
  int                 errors, pending;
  int                 idle_cnt = 0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion_top DUT (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .r00_i(r_i[0]), .r01_i(r_i[1]), .r02_i(r_i[2]),
    .r10_i(r_i[3]), .r11_i(r_i[4]), .r12_i(r_i[5]),
    .r20_i(r_i[6]), .r21_i(r_i[7]), .r22_i(r_i[8]),
    .valid_o, .qx_o, .qy_o, .qz_o, .qw_o, .degenerate_o
  );

  rotation_matrix_to_quaternion_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .r00_i(r_i[0]), .r01_i(r_i[1]), .r02_i(r_i[2]),
    .r10_i(r_i[3]), .r11_i(r_i[4]), .r12_i(r_i[5]),
    .r20_i(r_i[6]), .r21_i(r_i[7]), .r22_i(r_i[8]),
    .valid_o, .qx_o, .qy_o, .qz_o, .qw_o, .degenerate_o,
    .errors_o(errors), .pending_o(pending)
  );

  // watchdog: any cycle without a transaction on either channel counts
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("[rotation_matrix_to_quaternion_top] ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // one matrix transaction, with a random gap ahead of it
  task automatic send_matrix(input logic signed [15:0] m [9]);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    for (int a = 0; a < 9; a++) r_i[a] <= m[a];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic send_diag(input int d0, d1, d2, off);
    logic signed [15:0] m [9];
    for (int a = 0; a < 9; a++) m[a] = 16'(off);
    m[0] = 16'(d0); m[4] = 16'(d1); m[8] = 16'(d2);
    send_matrix(m);
  endtask

  initial begin
    logic signed [15:0] m [9];
    int                 mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity and the zero matrix take the trace path
    send_diag(16384, 16384, 16384, 0);
    send_diag(0, 0, 0, 0);
    // half turns about each axis: negative trace, each axis wins once
    send_diag(16384, -16384, -16384, 0);
    send_diag(-16384, 16384, -16384, 0);
    send_diag(-16384, -16384, 16384, 0);
    // diagonal ties, lower index must win
    send_diag(-16384, -16384, -16384, 0);
    send_diag(1000, 1000, -20000, 500);
    send_diag(-30000, 2000, 2000, -700);
    // near-degenerate radicand and full-scale extremes, saturation
    send_diag(16383, 16383, -32768, 32767);
    send_diag(32767, 32767, 32767, 32767);
    send_diag(32767, 32767, 32767, -32768);
    send_diag(-32768, -32768, -32768, 32767);
    send_diag(-32768, -32768, -32768, -32768);
    send_diag(0, 0, -1, -32768);
    send_diag(0, 0, -1, 32767);
    send_diag(0, 0, 0, 32767);
    // antisymmetric off-diagonals at the limits
    m = '{32767, -32768, 32767, 32767, -16384, -32768, -32768, 32767, 0};
    send_matrix(m);
    m = '{-32768, 32767, -32768, -32768, 16384, 32767, 32767, -32768, 0};
    send_matrix(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_matrix(m);

    for (int n = 0; n < NumRandom; n++) begin
      // drain the pipe once midway
      if (n == NumRandom / 2) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      for (int a = 0; a < 9; a++) begin
        case (mode)
          0: begin
            m[a] = 16'($urandom);
          end
          1: begin
            m[a] = 16'($signed($urandom_range(0, 32768)) - 16384);
          end
          2: begin
            m[a] = 16'($signed($urandom_range(0, 4096)) - 2048);
          end
          default: begin
            // strongly negative trace with one dominant diagonal term
            m[a] = 16'($signed($urandom_range(0, 16384)) - 8192);
          end
        endcase
      end
      if (mode == 3) begin
        m[0] = -$signed({1'b0, 15'($urandom)});
        m[4] = -$signed({1'b0, 15'($urandom)});
        m[8] = -$signed({1'b0, 15'($urandom)});
        m[4 * $urandom_range(0, 2)] = 16'($urandom_range(0, 16384));
      end
      send_matrix(m);
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[rotation_matrix_to_quaternion_top] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt_stage.sv
rtl/rmq_div_stage.sv
rtl/rotation_matrix_to_quaternion_top.sv
tb/sv/rotation_matrix_to_quaternion_checker.sv
tb/sv/rotation_matrix_to_quaternion_top_tb.sv
